[rtl/fmpll_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fmpll_pkg
// shared types, filter coefficient tables and sine table generator
// ----------------------------------------------------------------------------
package fmpll_pkg;

    localparam int DESIGN_TAPS = 20;
    localparam int PI_Q16      = 205887;

    typedef enum logic [3:0] {
        S_IDLE,
        S_FIR,
        S_PLL_ROM,
        S_PLL_MUL,
        S_PLL_GAIN,
        S_PLL_UPD,
        S_COS_ROM,
        S_MIX_MUL,
        S_MIX_PUSH,
        S_LPF,
        S_AUD_SUM,
        S_AUD_GAIN,
        S_AUD_PI,
        S_AUD_OUT
    } t_state;

    typedef enum logic [7:0] {
        REG_PILOT_INCREMENT = 8'd0,
        REG_PROP_GAIN       = 8'd1,
        REG_INTEG_GAIN      = 8'd2,
        REG_OUTPUT_GAIN     = 8'd3
    } t_reg_index;

    typedef struct packed {
        logic push;
        logic rot;
    } t_chain_ctl;

    // fold a tap index onto the half of a symmetric 20-tap design
    function automatic logic [3:0] fold_tap(input logic [6:0] k);
        logic [6:0] m;
        m = 7'(DESIGN_TAPS - 1) - k;
        return (k < m) ? k[3:0] : m[3:0];
    endfunction

    function automatic logic signed [15:0] pilot_coef(input logic [6:0] k);
        logic signed [15:0] c;
        c = '0;
        if (k < 7'(DESIGN_TAPS)) begin
            case (fold_tap(k))
                4'd0: c = 16'sd0;
                4'd1: c = -16'sd108;
                4'd2: c = -16'sd663;
                4'd3: c = -16'sd1808;
                4'd4: c = -16'sd3058;
                4'd5: c = -16'sd3124;
                4'd6: c = -16'sd568;
                4'd7: c = 16'sd4869;
                4'd8: c = 16'sd11400;
                4'd9: c = 16'sd15894;
                default: c = '0;
            endcase
        end
        return c;
    endfunction

    function automatic logic signed [15:0] band_coef(input logic [6:0] k);
        logic signed [15:0] c;
        c = '0;
        if (k < 7'(DESIGN_TAPS)) begin
            case (fold_tap(k))
                4'd0: c = 16'sd0;
                4'd1: c = -16'sd8;
                4'd2: c = 16'sd401;
                4'd3: c = 16'sd1456;
                4'd4: c = 16'sd1307;
                4'd5: c = -16'sd2869;
                4'd6: c = -16'sd9034;
                4'd7: c = -16'sd8665;
                4'd8: c = 16'sd2649;
                4'd9: c = 16'sd15344;
                default: c = '0;
            endcase
        end
        return c;
    endfunction

    function automatic logic signed [15:0] lp_coef(input logic [6:0] k);
        logic signed [15:0] c;
        c = '0;
        if (k < 7'(DESIGN_TAPS)) begin
            case (fold_tap(k))
                4'd0: c = 16'sd0;
                4'd1: c = 16'sd53;
                4'd2: c = 16'sd265;
                4'd3: c = 16'sd746;
                4'd4: c = 16'sd1613;
                4'd5: c = 16'sd2911;
                4'd6: c = 16'sd4552;
                4'd7: c = 16'sd6285;
                4'd8: c = 16'sd7750;
                4'd9: c = 16'sd8592;
                default: c = '0;
            endcase
        end
        return c;
    endfunction

    // 9-tap mono lowpass, symmetric around tap 4
    function automatic logic signed [15:0] mono_coef(input logic [6:0] k);
        logic signed [15:0] c;
        logic [6:0]         j;
        c = '0;
        j = (k <= 7'd4) ? k : 7'd8 - k;
        if (k < 7'd9) begin
            case (j[2:0])
                3'd0: c = 16'sd1092;
                3'd1: c = 16'sd3072;
                3'd2: c = 16'sd7981;
                3'd3: c = 16'sd13039;
                3'd4: c = 16'sd15167;
                default: c = '0;
            endcase
        end
        return c;
    endfunction

    // quarter-wave sine entry, evaluated at elaboration only
    function automatic logic [15:0] sine_entry(input int q, input int bits);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] s;
        x  = (64'(q) * 64'd1686629713) >> (bits - 2);
        x2 = (x * x) >> 30;
        t  = 64'd1073741824 - x2 / 72;
        t  = 64'd1073741824 - ((x2 * t) >> 30) / 42;
        t  = 64'd1073741824 - ((x2 * t) >> 30) / 20;
        t  = 64'd1073741824 - ((x2 * t) >> 30) / 6;
        s  = (x * t) >> 30;
        s  = (s * 64'd32767 + 64'd536870912) >> 30;
        return (s > 64'd32767) ? 16'd32767 : s[15:0];
    endfunction

endpackage

[rtl/fmpll_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fmpll_cell
// one history entry of a shifting chain
// ----------------------------------------------------------------------------
module fmpll_cell
    import fmpll_pkg::*;
#(
    parameter int WIDTH = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_shift,
    input  logic signed [WIDTH-1:0] i_data,
    output logic signed [WIDTH-1:0] o_data
);

    logic signed [WIDTH-1:0] r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_data <= '0;
        end else if (i_shift) begin
            r_data <= i_data;
        end
    end

    assign o_data = r_data;

endmodule

[rtl/fmpll_chain.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fmpll_chain
// row of history cells; push inserts a new sample, rot circulates the row
// ----------------------------------------------------------------------------
module fmpll_chain
    import fmpll_pkg::*;
#(
    parameter int WIDTH = 16,
    parameter int DEPTH = 20
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_chain_ctl              i_ctl,
    input  logic signed [WIDTH-1:0] i_data,
    output logic signed [WIDTH-1:0] o_tail
);

    logic signed [WIDTH-1:0] w_q [DEPTH];
    logic signed [WIDTH-1:0] w_head;

    assign w_head = i_ctl.push ? i_data : w_q[DEPTH-1];

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        if (g == 0) begin : g_first
            fmpll_cell #(.WIDTH(WIDTH)) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_shift (i_ctl.push | i_ctl.rot),
                .i_data  (w_head),
                .o_data  (w_q[g])
            );
        end else begin : g_next
            fmpll_cell #(.WIDTH(WIDTH)) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_shift (i_ctl.push | i_ctl.rot),
                .i_data  (w_q[g-1]),
                .o_data  (w_q[g])
            );
        end
    end

    assign o_tail = w_q[DEPTH-1];

endmodule

[rtl/fmpll_sine_rom.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fmpll_sine_rom
// quarter-wave sine table with registered read, full turn by folding
// ----------------------------------------------------------------------------
module fmpll_sine_rom
    import fmpll_pkg::*;
#(
    parameter int BITS = 10
) (
    input  logic                   i_clk,
    input  logic [BITS-1:0]        i_addr,
    output logic signed [15:0]     o_data
);

    localparam int QUARTER = 1 << (BITS - 2);

    logic [15:0]      w_tbl [QUARTER + 1];
    logic [BITS-2:0]  w_q;
    logic [BITS-2:0]  w_r;
    logic [15:0]      r_val;
    logic             r_neg;

    for (genvar g = 0; g <= QUARTER; g++) begin : g_tbl
        localparam logic [15:0] VAL = sine_entry(g, BITS);
        assign w_tbl[g] = VAL;
    end

    assign w_r = {1'b0, i_addr[BITS-3:0]};
    assign w_q = i_addr[BITS-2] ? ((BITS-1)'(QUARTER) - w_r) : w_r;

    always_ff @(posedge i_clk) begin
        r_val <= w_tbl[w_q];
        r_neg <= i_addr[BITS-1];
    end

    assign o_data = r_neg ? -$signed(r_val) : $signed(r_val);

endmodule

[rtl/fm_stereo_pilot_pll_decoder_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fm_stereo_pilot_pll_decoder_unit
// FM stereo multiplex decoder with pilot PLL
// ----------------------------------------------------------------------------
// One discriminator sample is taken per request. For each sample, the
// sample history circulates once through its row of cells past three
// multiply-accumulators (pilot bandpass, L-R bandpass, mono lowpass), then
// the PLL and the 38 kHz mixer run through the shared sine table. Every
// DECIMATION-th sample adds the L-R lowpass pass over the difference history
// and the audio scaling, and then presents one left/right request. A new
// sample is accepted only when the previous one has finished.
// Configuration is written through the cfg channel, which is always ready;
// writing pilot_increment also reloads the NCO step.
// ----------------------------------------------------------------------------
module fm_stereo_pilot_pll_decoder_unit
    import fmpll_pkg::*;
#(
    parameter int FILTER_TAPS     = 20,
    parameter int DECIMATION      = 16,
    parameter int SINE_TABLE_BITS = 10
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic signed [15:0] i_disc_sample,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [15:0] o_left_audio,
    output logic signed [15:0] o_right_audio,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [7:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data
);

    localparam int TAP_W = (FILTER_TAPS > 1) ? $clog2(FILTER_TAPS) : 1;
    localparam int DEC_W = (DECIMATION > 1) ? $clog2(DECIMATION) : 1;
    localparam int SB    = SINE_TABLE_BITS;

    t_state r_state, n_state;

    logic [15:0] r_prop_gain, r_integ_gain, r_output_gain;
    logic [31:0] r_phase, r_step;
    logic [DEC_W-1:0] r_dec;
    logic [TAP_W-1:0] r_tap;

    logic signed [39:0] r_acc_p, r_acc_b, r_acc_m, r_acc_s;
    logic signed [17:0] r_pilot, r_band, r_mono;
    logic signed [33:0] r_prod;
    logic signed [50:0] r_propm, r_integm;
    logic signed [34:0] r_mixp;
    logic signed [20:0] r_sum, r_dif;
    logic signed [37:0] r_gl, r_gr;
    logic signed [56:0] r_pl, r_pr;
    logic               r_out_valid;
    logic signed [15:0] r_left, r_right;

    t_chain_ctl              w_sctl, w_dctl;
    logic signed [15:0]      w_stail;
    logic signed [17:0]      w_dtail;
    logic signed [17:0]      w_mixed;
    logic signed [19:0]      w_mix_r;
    logic signed [19:0]      w_s;
    logic [31:0]             w_cidx;
    logic [SB-1:0]           w_rom_addr;
    logic signed [15:0]      w_sin;
    logic [6:0]              w_k;
    logic signed [35:0]      w_prop, w_integ;
    logic signed [24:0]      w_l, w_r;
    logic                    w_accept;
    logic                    w_out_free;

    assign o_ready     = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign w_accept    = i_valid && o_ready;
    assign w_out_free  = !r_out_valid || i_ready;
    assign w_k         = 7'(r_tap);

    fmpll_chain #(.WIDTH(16), .DEPTH(FILTER_TAPS)) u_samples (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_sctl),
        .i_data  (i_disc_sample),
        .o_tail  (w_stail)
    );

    fmpll_chain #(.WIDTH(18), .DEPTH(FILTER_TAPS)) u_diffs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_dctl),
        .i_data  (w_mixed),
        .o_tail  (w_dtail)
    );

    assign w_cidx     = {r_phase[30:0], 1'b0} + 32'h4000_0000;
    assign w_rom_addr = (r_state == S_COS_ROM) ? w_cidx[31 -: SB] : r_phase[31 -: SB];

    fmpll_sine_rom #(.BITS(SB)) u_rom (
        .i_clk  (i_clk),
        .i_addr (w_rom_addr),
        .o_data (w_sin)
    );

    // rounding and saturation
    assign w_prop  = 36'((r_propm + 51'sd16384) >>> 15);
    assign w_integ = 36'((r_integm + 51'sd4194304) >>> 23);
    assign w_mix_r = 20'((r_mixp + 35'sd16384) >>> 15);
    assign w_mixed = (w_mix_r > 20'sd131071)  ? 18'sd131071 :
                     (w_mix_r < -20'sd131072) ? -18'sd131072 : w_mix_r[17:0];
    assign w_s     = 20'((r_acc_s + 40'sd32768) >>> 16);
    assign w_l     = 25'((r_pl + 57'sd2147483648) >>> 32);
    assign w_r     = 25'((r_pr + 57'sd2147483648) >>> 32);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        w_sctl  = '0;
        w_dctl  = '0;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    w_sctl.push = 1'b1;
                    n_state     = S_FIR;
                end
            end
            S_FIR: begin
                w_sctl.rot = 1'b1;
                if (r_tap == '0) begin
                    n_state = S_PLL_ROM;
                end
            end
            S_PLL_ROM:  n_state = S_PLL_MUL;
            S_PLL_MUL:  n_state = S_PLL_GAIN;
            S_PLL_GAIN: n_state = S_PLL_UPD;
            S_PLL_UPD:  n_state = S_COS_ROM;
            S_COS_ROM:  n_state = S_MIX_MUL;
            S_MIX_MUL:  n_state = S_MIX_PUSH;
            S_MIX_PUSH: begin
                w_dctl.push = 1'b1;
                n_state = (r_dec == DEC_W'(DECIMATION - 1)) ? S_LPF : S_IDLE;
            end
            S_LPF: begin
                w_dctl.rot = 1'b1;
                if (r_tap == '0) begin
                    n_state = S_AUD_SUM;
                end
            end
            S_AUD_SUM:  n_state = S_AUD_GAIN;
            S_AUD_GAIN: n_state = S_AUD_PI;
            S_AUD_PI:   n_state = S_AUD_OUT;
            S_AUD_OUT: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prop_gain       <= 16'd655;
            r_integ_gain      <= 16'd419;
            r_output_gain     <= 16'd10000;
            r_phase           <= '0;
            r_step            <= 32'd318767104;
            r_dec             <= '0;
            r_tap             <= '0;
            r_out_valid       <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (t_reg_index'(i_cfg_index))
                    REG_PILOT_INCREMENT: r_step <= i_cfg_data;
                    REG_PROP_GAIN:   r_prop_gain   <= i_cfg_data[15:0];
                    REG_INTEG_GAIN:  r_integ_gain  <= i_cfg_data[15:0];
                    REG_OUTPUT_GAIN: r_output_gain <= i_cfg_data[15:0];
                    default: ;
                endcase
            end
            if (r_out_valid && i_ready && (r_state != S_AUD_OUT)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: r_tap <= TAP_W'(FILTER_TAPS - 1);
                S_FIR:  r_tap <= r_tap - 1'b1;
                S_LPF:  r_tap <= r_tap - 1'b1;
                S_PLL_UPD: begin
                    r_phase <= r_phase + r_step - w_prop[31:0];
                    r_step  <= r_step - w_integ[31:0];
                end
                S_MIX_PUSH: begin
                    r_tap <= TAP_W'(FILTER_TAPS - 1);
                    if (r_dec == DEC_W'(DECIMATION - 1)) begin
                        r_dec <= '0;
                    end else begin
                        r_dec <= r_dec + 1'b1;
                    end
                end
                S_AUD_OUT: begin
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_acc_p <= '0;
                r_acc_b <= '0;
                r_acc_m <= '0;
                r_acc_s <= '0;
            end
            S_FIR: begin
                r_acc_p <= r_acc_p + 40'(pilot_coef(w_k) * w_stail);
                r_acc_b <= r_acc_b + 40'(band_coef(w_k) * w_stail);
                r_acc_m <= r_acc_m + 40'(mono_coef(w_k) * w_stail);
            end
            S_PLL_ROM: begin
                r_pilot <= 18'((r_acc_p + 40'sd32768) >>> 16);
                r_band  <= 18'((r_acc_b + 40'sd32768) >>> 16);
                r_mono  <= 18'((r_acc_m + 40'sd32768) >>> 16);
            end
            S_PLL_MUL: r_prod <= 34'(r_pilot * w_sin);
            S_PLL_GAIN: begin
                r_propm  <= 51'($signed({1'b0, r_prop_gain}) * r_prod);
                r_integm <= 51'($signed({1'b0, r_integ_gain}) * r_prod);
            end
            S_MIX_MUL: r_mixp <= 35'(r_band * w_sin) <<< 1;
            S_LPF: r_acc_s <= r_acc_s + 40'(lp_coef(w_k) * w_dtail);
            S_AUD_SUM: begin
                r_sum <= 21'(r_mono) + 21'(w_s);
                r_dif <= 21'(r_mono) - 21'(w_s);
            end
            S_AUD_GAIN: begin
                r_gl <= 38'($signed({1'b0, r_output_gain}) * r_sum);
                r_gr <= 38'($signed({1'b0, r_output_gain}) * r_dif);
            end
            S_AUD_PI: begin
                r_pl <= 57'(r_gl * $signed(19'(PI_Q16)));
                r_pr <= 57'(r_gr * $signed(19'(PI_Q16)));
            end
            S_AUD_OUT: begin
                if (w_out_free) begin
                    r_left  <= (w_l > 25'sd32767)  ? 16'sd32767 :
                               (w_l < -25'sd32768) ? -16'sd32768 : w_l[15:0];
                    r_right <= (w_r > 25'sd32767)  ? 16'sd32767 :
                               (w_r < -25'sd32768) ? -16'sd32768 : w_r[15:0];
                end
            end
            default: ;
        endcase
    end

    assign o_valid       = r_out_valid;
    assign o_left_audio  = r_left;
    assign o_right_audio = r_right;

endmodule
